FILE: hdl/jsu_pkg.sv
// shared types and constants for the json string unescaper
// no dependencies; used by jsu_front, jsu_queue, jsu_back and the top level
package jsu_pkg;

  // decode modes of the front state machine
  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_TEXT       = 3'd1,
    MODE_ESC        = 3'd2,
    MODE_HEX        = 3'd3,
    MODE_AFTER_HIGH = 3'd4,
    MODE_HIGH_BSL   = 3'd5,
    MODE_LOW_HEX    = 3'd6
  } mode_e;

  // at most four decoded bytes and one terminator per input item
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned ByteIw   = 2;
  localparam int unsigned CntW     = 3;

  // record queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;

  localparam logic [15:0] SurrHiFirst = 16'hD800;
  localparam logic [15:0] SurrHiLast  = 16'hDBFF;
  localparam logic [31:0] SurrLoBase  = 32'h0000DC00;
  localparam logic [31:0] SurrHiBase  = 32'h0000D800;
  localparam logic [31:0] PlaneOne    = 32'h00010000;

  // results caused by one item: bytes first, then an optional terminator
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          nbytes;
    logic                     term;
  } rec_t;

endpackage

FILE: hdl/jsu_front.sv
// front part: accepts raw string bytes, runs the escape decoder and builds one
// result record per item; depends on jsu_pkg
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    data_byte_i,
  input  logic          start_of_string_i,
  input  logic          end_of_buffer_i,
  input  logic          accept_i,
  output logic          wr_o,
  output jsu_pkg::rec_t rec_o
);

  typedef struct packed {
    jsu_pkg::mode_e mode;
    jsu_pkg::rec_t  rec;
  } tstate_t;

  jsu_pkg::mode_e mode_q, mode_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [15:0]    acc_q, acc_d;
  logic [15:0]    hi_q, hi_d;
  logic [7:0]     pend_q [3];
  logic [7:0]     pend_d [3];

  tstate_t     st;
  logic [15:0] acc_n;
  logic [31:0] full_cp;
  logic        tail_en;

  function automatic logic [3:0] nibble(logic [7:0] h);
    logic [3:0] n;
    n = 4'd0;
    if (h >= 8'h30 && h <= 8'h39) n = 4'(h - 8'h30);
    else if (h >= 8'h61 && h <= 8'h66) n = 4'(h - 8'h57);
    else if (h >= 8'h41 && h <= 8'h46) n = 4'(h - 8'h37);
    return n;
  endfunction

  function automatic jsu_pkg::rec_t put_byte(jsu_pkg::rec_t r, logic [7:0] b);
    jsu_pkg::rec_t o;
    o = r;
    if (r.nbytes < jsu_pkg::CntW'(jsu_pkg::MaxBytes)) begin
      o.bytes[r.nbytes[jsu_pkg::ByteIw-1:0]] = b;
      o.nbytes = r.nbytes + jsu_pkg::CntW'(1);
    end
    return o;
  endfunction

  function automatic jsu_pkg::rec_t put_utf8(jsu_pkg::rec_t r, logic [15:0] cp);
    jsu_pkg::rec_t o;
    o = r;
    if (cp < 16'h0080) begin
      o = put_byte(o, cp[7:0]);
    end else if (cp < 16'h0800) begin
      o = put_byte(o, {3'b110, cp[10:6]});
      o = put_byte(o, {2'b10, cp[5:0]});
    end else begin
      o = put_byte(o, {4'hE, cp[15:12]});
      o = put_byte(o, {2'b10, cp[11:6]});
      o = put_byte(o, {2'b10, cp[5:0]});
    end
    return o;
  endfunction

  // one byte of plain text or of an escape; a u opens a hex group if can_hex
  function automatic tstate_t text_step(tstate_t s, logic [7:0] b, logic can_hex);
    tstate_t r;
    r = s;
    unique case (s.mode)
      jsu_pkg::MODE_TEXT: begin
        if (b == jsu_pkg::ChQuote) begin
          r.rec.term = 1'b1;
          r.mode     = jsu_pkg::MODE_IDLE;
        end else if (b == jsu_pkg::ChBsl) begin
          r.mode = jsu_pkg::MODE_ESC;
        end else begin
          r.rec = put_byte(s.rec, b);
        end
      end
      jsu_pkg::MODE_ESC: begin
        r.mode = jsu_pkg::MODE_TEXT;
        unique case (b)
          jsu_pkg::ChB: r.rec = put_byte(s.rec, 8'h08);
          jsu_pkg::ChF: r.rec = put_byte(s.rec, 8'h0C);
          jsu_pkg::ChN: r.rec = put_byte(s.rec, 8'h0A);
          jsu_pkg::ChR: r.rec = put_byte(s.rec, 8'h0D);
          jsu_pkg::ChT: r.rec = put_byte(s.rec, 8'h09);
          jsu_pkg::ChU: begin
            if (can_hex) r.mode = jsu_pkg::MODE_HEX;
          end
          default: r.rec = put_byte(s.rec, b);
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  assign acc_n   = {acc_q[11:0], nibble(data_byte_i)};
  // 0x10000 + (((hi - 0xD800) << 10) | (lo - 0xDC00)), wrapping
  assign full_cp = jsu_pkg::PlaneOne +
                   (((32'(hi_q) - jsu_pkg::SurrHiBase) << 10) |
                    (32'(acc_n) - jsu_pkg::SurrLoBase));

  always_comb begin : next_state
    st.mode = mode_q;
    st.rec  = '0;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    hi_d    = hi_q;
    pend_d  = pend_q;
    tail_en = 1'b1;

    if (start_of_string_i) begin
      st.mode = jsu_pkg::MODE_TEXT;
      cnt_d   = 2'd0;
      acc_d   = 16'd0;
      hi_d    = 16'd0;
      tail_en = 1'b0;
      if (end_of_buffer_i) begin
        st.rec.term = 1'b1;
        st.mode     = jsu_pkg::MODE_IDLE;
      end
    end else begin
      unique case (mode_q) inside
        jsu_pkg::MODE_TEXT, jsu_pkg::MODE_ESC: begin
          st = text_step(st, data_byte_i, !end_of_buffer_i);
          if (st.mode == jsu_pkg::MODE_HEX) begin
            cnt_d = 2'd0;
            acc_d = 16'd0;
          end
        end
        jsu_pkg::MODE_HEX: begin
          if (cnt_q != 2'd3) begin
            pend_d[cnt_q] = data_byte_i;
            cnt_d         = cnt_q + 2'd1;
            acc_d         = acc_n;
            if (end_of_buffer_i) begin
              // short group: replay the digits as plain text, u dropped
              st.mode = jsu_pkg::MODE_TEXT;
              cnt_d   = 2'd0;
              for (int k = 0; k < 3; k++) begin
                if (k <= int'(cnt_q) && st.mode != jsu_pkg::MODE_IDLE) begin
                  st = text_step(st, pend_d[k], 1'b0);
                end
              end
            end
          end else begin
            cnt_d = 2'd0;
            acc_d = 16'd0;
            if (acc_n >= jsu_pkg::SurrHiFirst && acc_n <= jsu_pkg::SurrHiLast &&
                !end_of_buffer_i) begin
              hi_d    = acc_n;
              st.mode = jsu_pkg::MODE_AFTER_HIGH;
            end else begin
              st.rec  = put_utf8(st.rec, acc_n);
              st.mode = jsu_pkg::MODE_TEXT;
            end
          end
        end
        jsu_pkg::MODE_AFTER_HIGH: begin
          if (data_byte_i == jsu_pkg::ChBsl && !end_of_buffer_i) begin
            st.mode = jsu_pkg::MODE_HIGH_BSL;
          end else begin
            st.rec  = put_utf8(st.rec, hi_q);
            st.mode = jsu_pkg::MODE_TEXT;
            st      = text_step(st, data_byte_i, !end_of_buffer_i);
          end
        end
        jsu_pkg::MODE_HIGH_BSL: begin
          if (data_byte_i == jsu_pkg::ChU) begin
            st.mode = jsu_pkg::MODE_LOW_HEX;
            cnt_d   = 2'd0;
            acc_d   = 16'd0;
          end else begin
            // lone high half, then the byte taken as an escape
            st.rec  = put_utf8(st.rec, hi_q);
            st.mode = jsu_pkg::MODE_ESC;
            st      = text_step(st, data_byte_i, !end_of_buffer_i);
          end
        end
        jsu_pkg::MODE_LOW_HEX: begin
          if (cnt_q != 2'd3) begin
            cnt_d = cnt_q + 2'd1;
            acc_d = acc_n;
          end else begin
            st.rec  = put_byte(st.rec, 8'hF0 | full_cp[25:18]);
            st.rec  = put_byte(st.rec, {2'b10, full_cp[17:12]});
            st.rec  = put_byte(st.rec, {2'b10, full_cp[11:6]});
            st.rec  = put_byte(st.rec, {2'b10, full_cp[5:0]});
            cnt_d   = 2'd0;
            acc_d   = 16'd0;
            st.mode = jsu_pkg::MODE_TEXT;
          end
        end
        default: begin
          // no string open: byte ignored
          st.mode = jsu_pkg::MODE_IDLE;
          tail_en = 1'b0;
        end
      endcase
    end

    // end of buffer closes a string still open
    if (tail_en && end_of_buffer_i && st.mode != jsu_pkg::MODE_IDLE) begin
      st.rec.term = 1'b1;
      st.mode     = jsu_pkg::MODE_IDLE;
      cnt_d       = 2'd0;
      acc_d       = 16'd0;
    end
    mode_d = st.mode;
  end

  always_comb begin : outputs
    rec_o = st.rec;
    wr_o  = accept_i && (st.rec.nbytes != '0 || st.rec.term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_IDLE;
      cnt_q  <= 2'd0;
      acc_q  <= 16'd0;
      hi_q   <= 16'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      hi_q   <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

FILE: hdl/jsu_queue.sv
// short record queue between the decoder front and the result back
// depends on jsu_pkg
module jsu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  jsu_pkg::rec_t wr_rec_i,
  output logic          full_o,
  input  logic          rd_i,
  output jsu_pkg::rec_t rd_rec_o,
  output logic          empty_o
);

  jsu_pkg::rec_t              mem_q [jsu_pkg::QDepth];
  logic [jsu_pkg::QAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [jsu_pkg::QAw:0]      count_q, count_d;
  logic                       do_wr, do_rd;

  assign full_o   = count_q == (jsu_pkg::QAw+1)'(jsu_pkg::QDepth);
  assign empty_o  = count_q == '0;
  assign rd_rec_o = mem_q[rd_ptr_q];
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) count_d = count_q + (jsu_pkg::QAw+1)'(1);
    else if (do_rd && !do_wr) count_d = count_q - (jsu_pkg::QAw+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + jsu_pkg::QAw'(1);
      if (do_rd) rd_ptr_q <= rd_ptr_q + jsu_pkg::QAw'(1);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_rec_i;
  end

endmodule

FILE: hdl/jsu_back.sv
// back part: holds one record and hands out its results one per pop
// depends on jsu_pkg
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jsu_pkg::rec_t rec_i,
  input  logic          avail_i,
  output logic          take_o,
  output logic [7:0]    out_byte_o,
  output logic          byte_present_o,
  output logic          string_done_o,
  output logic          empty_o,
  input  logic          pop_i
);

  jsu_pkg::rec_t             cur_q;
  logic                      valid_q;
  logic [jsu_pkg::CntW-1:0]  idx_q;
  logic [jsu_pkg::CntW-1:0]  total;
  logic                      is_byte, last, popped, free;

  assign total   = cur_q.nbytes + jsu_pkg::CntW'(cur_q.term);
  assign is_byte = idx_q < cur_q.nbytes;
  assign last    = (idx_q + jsu_pkg::CntW'(1)) == total;
  assign popped  = pop_i && valid_q;
  // slot frees when empty or when its last result leaves now
  assign free    = !valid_q || (popped && last);
  assign take_o  = free && avail_i;

  assign empty_o        = !valid_q;
  assign out_byte_o     = is_byte ? cur_q.bytes[idx_q[jsu_pkg::ByteIw-1:0]] : 8'h00;
  assign byte_present_o = is_byte;
  assign string_done_o  = !is_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (free) begin
      valid_q <= avail_i;
      idx_q   <= '0;
    end else if (popped) begin
      idx_q <= idx_q + jsu_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) cur_q <= rec_i;
  end

endmodule

FILE: hdl/json_string_unescape_core.sv
// json string unescaper top level: front decoder, record queue, result back
// path: an item's first result is written into the queue at the edge that accepts it
// and moves from there into the back slot once it is free; that slot drives the ports
// throughput: one item per cycle while not full and each gives at most one result;
// n results of an item hold the output for n pops; a four-record queue absorbs bursts
// reset: asynchronous, active low; clears the decoder state and the queue
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
module json_string_unescape_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       start_of_string_i,
  input  logic       end_of_buffer_i,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       string_done_o,
  output logic       empty,
  input  logic       pop
);

  jsu_pkg::rec_t wr_rec, rd_rec;
  logic          wr, q_full, q_empty, take, accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  jsu_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .data_byte_i       (data_byte_i),
    .start_of_string_i (start_of_string_i),
    .end_of_buffer_i   (end_of_buffer_i),
    .accept_i          (accept),
    .wr_o              (wr),
    .rec_o             (wr_rec)
  );

  jsu_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .wr_rec_i (wr_rec),
    .full_o   (q_full),
    .rd_i     (take),
    .rd_rec_o (rd_rec),
    .empty_o  (q_empty)
  );

  jsu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_i          (rd_rec),
    .avail_i        (!q_empty),
    .take_o         (take),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .string_done_o  (string_done_o),
    .empty_o        (empty),
    .pop_i          (pop)
  );

endmodule
